// File: sv/interface_strength_histogram_assert.svh
// Assertion macros used by the checker; clk and arst_n must exist in scope.
`ifndef INTERFACE_STRENGTH_HISTOGRAM_ASSERT_SVH
`define INTERFACE_STRENGTH_HISTOGRAM_ASSERT_SVH

// Same-cycle implication.
`define ISH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ISH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ish_pkg.sv
package ish_pkg;

	// fixed field widths
	localparam int unsigned REQ_W     = 2;
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned IDX_W     = 7;
	localparam int unsigned RSP_CNT_W = 32;

	// defaults for the top-level parameters
	localparam int unsigned DEF_IFACE_BITS = 64;
	localparam int unsigned DEF_MAX_WORDS  = 16;
	localparam int unsigned DEF_COUNT_BITS = 32;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// request codes on the wire
	localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_READ,
		OP_CLEAR,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_READ,
		BK_CLEAR
	} back_state_t;

	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] word;
		logic              last;
		logic [IDX_W-1:0]  idx;
	} ish_item_t;

endpackage

// File: sv/ish_if.sv
interface ish_req_if import ish_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [WORD_W-1:0] interface_word;
	logic              last_of_genome;
	logic [IDX_W-1:0]  bin_index;

	modport source (output valid, req_type, interface_word, last_of_genome, bin_index,
		input ready);
	modport sink (input valid, req_type, interface_word, last_of_genome, bin_index,
		output ready);
endinterface

interface ish_rsp_if import ish_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [IDX_W-1:0]     bin_number;
	logic [RSP_CNT_W-1:0] bin_count;

	modport source (output valid, bin_number, bin_count, input ready);
	modport sink (input valid, bin_number, bin_count, output ready);
endinterface

// File: sv/ish_front.sv
module ish_front import ish_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ish_req_if.sink   req,
	output logic      q_valid,
	input  logic      q_ready,
	output ish_item_t q_item
);

	localparam int unsigned QP_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);

	ish_item_t         fifo_q [QUEUE_DEPTH];
	logic [QP_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QC_W-1:0]   cnt_q;
	op_t               op_d;
	logic              push, pop;

	// decode the request code
	always_comb begin
		unique case (req.req_type)
			REQ_PUSH:  op_d = OP_PUSH;
			REQ_READ:  op_d = OP_READ;
			REQ_CLEAR: op_d = OP_CLEAR;
			default:   op_d = OP_NONE;
		endcase
	end

	assign req.ready = (cnt_q != QC_W'(QUEUE_DEPTH));
	// unknown codes are taken and dropped here
	assign push      = req.valid && req.ready && (op_d != OP_NONE);
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_item    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{op: op_d, word: req.interface_word,
				last: req.last_of_genome, idx: req.bin_index};
		end
	end

endmodule

// File: sv/ish_back.sv
module ish_back import ish_pkg::*; #(
	parameter int unsigned IFACE_BITS = DEF_IFACE_BITS,
	parameter int unsigned MAX_WORDS  = DEF_MAX_WORDS,
	parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  ish_item_t q_item,
	ish_rsp_if.source rsp
);

	localparam int unsigned NBINS     = (IFACE_BITS * 3) / 2 + 2;
	localparam int unsigned SELF_BASE = (IFACE_BITS * 3) / 2 + 1;
	localparam int unsigned BIN_W     = $clog2(NBINS);
	localparam int unsigned WIDX_W    = $clog2(MAX_WORDS);
	localparam int unsigned CNT_W     = $clog2(MAX_WORDS + 1);
	localparam int unsigned PC_W      = $clog2(IFACE_BITS + 1);

	back_state_t state_q, state_d;

	logic [CNT_W-1:0]      stored_q, k_q;
	logic [IFACE_BITS-1:0] cur_w_q, cur_rw_q, rw_d;
	logic                  cur_last_q;
	logic [IDX_W-1:0]      cur_idx_q;

	logic load, issue, st_we, inj_rd, do_clear, drop_clr, pipe_empty;

	// word store
	logic [IFACE_BITS-1:0] store_mem [MAX_WORDS];
	logic [WIDX_W-1:0]     st_raddr;

	// bin store with per-bin valid bits
	logic [COUNT_BITS-1:0] bins_mem [NBINS];
	logic [NBINS-1:0]      bin_valid_q;

	// distance pipeline
	logic                  v_s1, v_s2, v_s3;
	logic                  self_s1;
	logic [IFACE_BITS-1:0] store_rd_s1, a_s1;
	logic [PC_W-1:0]       pc_s1;
	logic [BIN_W-1:0]      bin_s1;
	logic [BIN_W-1:0]      bin_s2, bin_s3;
	logic                  rd_s2, rd_s3, oor_s2, oor_s3;
	logic [IDX_W-1:0]      idx_s2, idx_s3;
	logic [COUNT_BITS-1:0] rdata_s3;
	logic                  bv_s3;

	// last write, for forwarding into a read issued on the same edge
	logic                  wv_q;
	logic [BIN_W-1:0]      wbin_q;
	logic [COUNT_BITS-1:0] wval_q;

	logic [COUNT_BITS-1:0]           base_s3, new_s3;
	logic [COUNT_BITS+RSP_CNT_W-1:0] wide_s3;

	logic                 out_valid_q;
	logic [IDX_W-1:0]     out_bin_q;
	logic [RSP_CNT_W-1:0] out_cnt_q;

	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;

	// mirrored complement of the incoming word
	always_comb begin
		for (int i = 0; i < IFACE_BITS; i++) begin
			rw_d[i] = ~q_item.word[IFACE_BITS-1-i];
		end
	end

	always_comb begin
		state_d  = state_q;
		q_ready  = 1'b0;
		load     = 1'b0;
		issue    = 1'b0;
		st_we    = 1'b0;
		inj_rd   = 1'b0;
		do_clear = 1'b0;
		drop_clr = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					load = 1'b1;
					case (q_item.op)
						OP_PUSH: begin
							if (stored_q < CNT_W'(MAX_WORDS)) begin
								state_d = BK_ISSUE;
							end else begin
								drop_clr = q_item.last;
							end
						end
						OP_READ:  state_d = BK_READ;
						OP_CLEAR: state_d = BK_CLEAR;
						default:  state_d = BK_IDLE;
					endcase
				end
			end
			BK_ISSUE: begin
				issue = 1'b1;
				if (k_q == stored_q) begin
					st_we   = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_READ: begin
				if (pipe_empty && !out_valid_q) begin
					inj_rd  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_CLEAR: begin
				if (pipe_empty) begin
					do_clear = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
		end else begin
			state_q     <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			stored_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			wv_q        <= 1'b0;
			bin_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
			if (st_we) begin
				stored_q <= cur_last_q ? '0 : stored_q + 1'b1;
			end else if (drop_clr) begin
				stored_q <= '0;
			end
			v_s1 <= issue;
			v_s2 <= v_s1 || inj_rd;
			v_s3 <= v_s2;
			wv_q <= v_s3 && !rd_s3;
			if (do_clear) begin
				bin_valid_q <= '0;
			end else if (v_s3 && !rd_s3) begin
				bin_valid_q[bin_s3] <= 1'b1;
			end
			if (v_s3 && rd_s3) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// word store: one write, one registered read
	assign st_raddr = (k_q == '0) ? '0 : WIDX_W'(k_q - 1'b1);

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[stored_q[WIDX_W-1:0]] <= cur_w_q;
		end
		if (issue) begin
			store_rd_s1 <= store_mem[st_raddr];
		end
	end

	// s1: distance and target bin
	assign a_s1  = self_s1 ? cur_w_q : store_rd_s1;
	assign pc_s1 = PC_W'($countones(a_s1 ^ cur_rw_q));
	assign bin_s1 = self_s1 ? (BIN_W'(SELF_BASE) - BIN_W'(pc_s1 >> 1))
		: (BIN_W'(IFACE_BITS) - BIN_W'(pc_s1));

	// s3: forward, saturate
	assign base_s3 = (wv_q && (wbin_q == bin_s3)) ? wval_q : (bv_s3 ? rdata_s3 : '0);
	assign new_s3  = (&base_s3) ? base_s3 : base_s3 + 1'b1;
	assign wide_s3 = {{RSP_CNT_W{1'b0}}, base_s3};

	always_ff @(posedge clk) begin
		if (load) begin
			cur_w_q    <= q_item.word[IFACE_BITS-1:0];
			cur_rw_q   <= rw_d;
			cur_last_q <= q_item.last;
			cur_idx_q  <= q_item.idx;
		end
		self_s1 <= (k_q == '0);
		if (inj_rd) begin
			oor_s2 <= (cur_idx_q >= IDX_W'(NBINS));
			bin_s2 <= (cur_idx_q >= IDX_W'(NBINS)) ? '0 : cur_idx_q[BIN_W-1:0];
		end else begin
			oor_s2 <= 1'b0;
			bin_s2 <= bin_s1;
		end
		rd_s2    <= inj_rd;
		idx_s2   <= cur_idx_q;
		bin_s3   <= bin_s2;
		rd_s3    <= rd_s2;
		oor_s3   <= oor_s2;
		idx_s3   <= idx_s2;
		bv_s3    <= bin_valid_q[bin_s2];
		wbin_q   <= bin_s3;
		wval_q   <= new_s3;
		if (v_s3 && rd_s3) begin
			out_bin_q <= idx_s3;
			out_cnt_q <= oor_s3 ? '0 : wide_s3[RSP_CNT_W-1:0];
		end
	end

	// bin store: one write, one registered read
	always_ff @(posedge clk) begin
		if (v_s3 && !rd_s3) begin
			bins_mem[bin_s3] <= new_s3;
		end
		rdata_s3 <= bins_mem[bin_s2];
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.bin_number = out_bin_q;
	assign rsp.bin_count  = out_cnt_q;

endmodule

// File: sv/interface_strength_histogram.sv
// Interface strength histogram.
// req channel: one beat per request. req_type 0 pushes interface_word (flag
// last_of_genome ends the genome and empties the word store), 1 reads bin
// bin_index, 2 zeroes every bin, 3 is taken and ignored.
// rsp channel: one beat per read, carrying bin_number and bin_count; counts
// saturate, and a bin past the last one reads as zero.
// A four-entry queue sits between the request decoder and the execution unit,
// so requests are taken while the unit is busy or a result waits.
// Throughput: a push occupies the execution unit for one self bin plus one bin
// per stored word, one bin update per cycle through a three-stage distance /
// read / update pipe; a dropped push (store full) issues no bins. A read waits
// for the pipe to drain and for the result register to be free; a clear also
// waits for the pipe to drain.
// Reset: all bins read as zero at once (per-bin valid bits), word store empty;
// no clearing pass is needed.
// A stalled receiver holds the result register; the unit then stops at the
// next read while the queue keeps filling until it is full.
module interface_strength_histogram import ish_pkg::*; #(
	parameter int unsigned IFACE_BITS = DEF_IFACE_BITS,
	parameter int unsigned MAX_WORDS  = DEF_MAX_WORDS,
	parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	ish_req_if.sink   req,
	ish_rsp_if.source rsp
);

	// queue head towards the execution unit
	logic      q_valid;
	logic      q_ready;
	ish_item_t q_item;

	// request decoder and queue
	ish_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	// execution unit: word store, distance pipe, bin store, result register
	ish_back #(
		.IFACE_BITS (IFACE_BITS),
		.MAX_WORDS  (MAX_WORDS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.rsp     (rsp)
	);

endmodule

// File: sv/ish_checker.sv
`include "interface_strength_histogram_assert.svh"

module ish_checker import ish_pkg::*; #(
	parameter int unsigned IFACE_BITS = DEF_IFACE_BITS
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [IDX_W-1:0]     bin_number,
	input logic [RSP_CNT_W-1:0] bin_count
);

	localparam int unsigned NBINS = (IFACE_BITS * 3) / 2 + 2;

	// stalled result beat holds
	`ISH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(bin_number) && $stable(bin_count), "result beat changed while stalled")

	// bins past the end read as zero
	`ISH_ASSERT_NOW(a_oor_zero, rsp_valid && (bin_number >= IDX_W'(NBINS)), bin_count == '0, "out-of-range bin returned a count")

	// the queue only fills on accepted beats
	`ISH_ASSERT_NEXT(a_ready_keep, req_ready && !req_valid, req_ready, "request ready dropped with no beat taken")

endmodule

bind interface_strength_histogram ish_checker #(.IFACE_BITS(IFACE_BITS)) u_ish_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.bin_number (rsp.bin_number),
	.bin_count  (rsp.bin_count)
);
